FILE: rtl/assert_macros.svh
// Assertion macros for the sparse matvec RTL.
// Expects clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled during reset.
`define CSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in this cycle, consequent in the next.
`define CSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  `CSM_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: rtl/csm_pkg.sv
// Package for the CSR sparse matvec core: field widths, item kinds,
// vector store sizing and the stage struct. No dependencies.
package csm_pkg;

  localparam int VECTOR_DEPTH = 1024;
  localparam int VEC_AW       = $clog2(VECTOR_DEPTH);
  localparam int INDEX_W      = 10;
  localparam int VALUE_W      = 32;
  localparam int ROW_W        = 16;
  localparam int PROD_W       = 2 * VALUE_W;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_BEGIN   = 2'd1,
    KIND_NONZERO = 2'd2
  } csm_kind_t;

  typedef struct packed {
    logic                      valid;
    logic                      is_begin;
    logic                      last;
    logic                      in_range;
    logic signed [VALUE_W-1:0] value;
  } csm_item_t;

  function automatic logic [VEC_AW-1:0] vec_addr(input logic [INDEX_W-1:0] index);
    logic [31:0] wide;
    wide = 32'(index);
    return wide[VEC_AW-1:0];
  endfunction

  function automatic logic vec_in_range(input logic [INDEX_W-1:0] index);
    return 32'(index) < 32'(VECTOR_DEPTH);
  endfunction

endpackage

FILE: rtl/csr_sparse_matvec_core.sv
// CSR sparse matvec core top level: input stage, vector store and MAC.
// Depends on csm_pkg, csm_vec_ram and csm_mac.
// A closing item's result passes s1, s2, then the output register.
// Throughput: one item per cycle; intake holds only while a new row result
// meets an output register whose result is not taken.
// Reset: clears accumulator, row counter and valids; vector store undefined.
module csr_sparse_matvec_core import csm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,    // index[9:0], value[41:10], zero[47:42]
  input  logic [1:0]  s_tuser,    // kind[1:0]
  input  logic        s_tlast,    // row_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata     // row_number[15:0], row_result[47:16]
);

  logic                      en;
  logic                      accept;
  logic [INDEX_W-1:0]        in_index;
  logic signed [VALUE_W-1:0] in_value;
  logic                      in_range;
  logic                      is_load;
  logic                      is_row;
  logic [VALUE_W-1:0]        ram_rdata;
  csm_item_t                 s1;

  assign s_tready = en;
  assign accept   = s_tvalid && s_tready;
  assign in_index = s_tdata[INDEX_W-1:0];
  assign in_value = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];
  assign in_range = vec_in_range(in_index);
  assign is_load  = s_tuser == KIND_LOAD;
  assign is_row   = s_tuser == KIND_BEGIN || s_tuser == KIND_NONZERO;

  csm_vec_ram #(
    .DEPTH (VECTOR_DEPTH),
    .WIDTH (VALUE_W)
  ) u_ram (
    .clk   (clk),
    .we    (accept && is_load && in_range),
    .re    (en),
    .addr  (vec_addr(in_index)),
    .wdata (in_value),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (en) begin
      s1.valid <= accept && is_row;
    end
    if (en) begin
      s1.is_begin <= s_tuser == KIND_BEGIN;
      s1.last     <= s_tlast;
      s1.in_range <= in_range;
      s1.value    <= in_value;
    end
  end

  csm_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .s1       (s1),
    .x_data   (ram_rdata),
    .en       (en),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

FILE: rtl/csm_vec_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module csm_vec_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: rtl/csm_mac.sv
// Multiply stage, saturating accumulator, row counter and output register.
// Depends on csm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csm_mac import csm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  csm_item_t                s1,
  input  logic signed [VALUE_W-1:0] x_data,
  output logic                     en,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [47:0]              m_tdata    // row_number[15:0], row_result[47:16]
);

  logic                      s2_valid;
  logic                      s2_is_begin;
  logic                      s2_last;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [VALUE_W-1:0] x_eff;
  logic signed [VALUE_W-1:0] acc;
  logic signed [VALUE_W-1:0] acc_next;
  logic signed [PROD_W-16:0] sum;
  logic [ROW_W-1:0]          row_counter;
  logic                      emit;
  logic                      out_load;

  always_comb begin
    x_eff = s1.in_range ? x_data : '0;
    if (s1.is_begin) begin
      prod_next = PROD_W'(s1.value);
    end else begin
      prod_next = s1.value * x_eff;
    end
  end

  always_comb begin
    sum = (PROD_W-15)'(acc) + (PROD_W-15)'(prod >>> 16);
    if (s2_is_begin) begin
      acc_next = prod[VALUE_W-1:0];
    end else if (sum[PROD_W-16:VALUE_W-1] != '0 && sum[PROD_W-16:VALUE_W-1] != '1) begin
      acc_next = sum[PROD_W-16] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      acc_next = sum[VALUE_W-1:0];
    end
  end

  assign emit     = s2_valid && s2_last;
  assign en       = !(emit && m_tvalid && !m_tready);
  assign out_load = en && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_is_begin <= s1.is_begin;
      s2_last     <= s1.last;
      prod        <= prod_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      row_counter <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (en && s2_valid) begin
        acc <= acc_next;
      end
      if (out_load) begin
        row_counter <= row_counter + 16'd1;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {acc_next, row_counter};
    end
  end

  `CSM_ASSERT_NEXT(row_step, out_load, row_counter == $past(row_counter) + 16'd1,
                   "row counter did not advance on result")
  `CSM_ASSERT_NEXT(emit_shown, out_load, m_tvalid && m_tdata[15:0] == $past(row_counter),
                   "result not presented with its row number")
  `CSM_ASSERT_NEXT(begin_load, en && s2_valid && s2_is_begin, acc == $past(prod[VALUE_W-1:0]),
                   "begin row did not load accumulator")

endmodule
